@@ hdl/lzwsc_pkg.sv @@
`timescale 1ns / 1ps

package lzwsc_pkg;

    // Dictionary and lookup sizing.
    localparam int DICT_ENTRIES   = 16384;
    localparam int LOOKUP_BUCKETS = 32768;
    localparam int LIT_COUNT      = 256;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = $clog2(DICT_ENTRIES);
    localparam int CNT_W   = CODE_W + 1;
    localparam int KEY_W   = CODE_W + BYTE_W;
    localparam int BKT_W   = $clog2(LOOKUP_BUCKETS);
    localparam int WIDTH_W = 4;
    localparam int EPOCH_W = 8;

    localparam logic [WIDTH_W-1:0] START_WIDTH = WIDTH_W'(9);
    localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(15);
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in;

    // Output transaction payload.
    typedef struct packed {
        logic [13:0] code_value;
        logic [3:0]  code_bits;
        logic        is_escape;
        logic        last_code;
    } t_out;

    // Code handed from the dictionary engine to the code sequencer.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_emit_req;

    // One lookup bucket; an epoch other than the current one means empty.
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
    } t_bucket;

    localparam int BUCKET_W = $bits(t_bucket);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_EMIT,
        S_CLEAR
    } t_core_state;

    // Home bucket of a (prefix, byte) key: the key folded onto the index width.
    function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] upper;
        upper = key >> BKT_W;
        return key[BKT_W-1:0] ^ upper[BKT_W-1:0];
    endfunction

endpackage

@@ hdl/lzwsc_ram.sv @@
`timescale 1ns / 1ps

module lzwsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ hdl/lzwsc_emit.sv @@
`timescale 1ns / 1ps

module lzwsc_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  lzwsc_pkg::t_emit_req  i_req,
    output logic                  o_req_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output lzwsc_pkg::t_out       o_out
);
    import lzwsc_pkg::*;

    logic                r_req_v, n_req_v;
    t_emit_req           r_req, n_req;
    logic [WIDTH_W-1:0]  r_width, n_width;
    logic [CNT_W-1:0]    r_limit, n_limit;
    logic                r_out_v, n_out_v;
    t_out                r_out, n_out;

    logic out_free;
    logic need_esc;
    logic fire;
    logic done;

    // An escape is due while the code does not fit below the current limit.
    assign out_free    = !r_out_v || !i_out_stall;
    assign need_esc    = (CNT_W'(r_req.code) >= r_limit) && (r_width < MAX_WIDTH);
    assign fire        = r_req_v && out_free;
    assign done        = fire && !need_esc;
    assign o_req_ready = !r_req_v || done;

    // Next values: one escape or the code itself per free output slot.
    always_comb begin
        n_req_v = r_req_v;
        n_req   = r_req;
        n_width = r_width;
        n_limit = r_limit;
        n_out_v = r_out_v;
        n_out   = r_out;
        if (fire) begin
            n_out_v = 1'b1;
            if (need_esc) begin
                n_out.code_value = r_limit[13:0];
                n_out.code_bits  = r_width;
                n_out.is_escape  = 1'b1;
                n_out.last_code  = 1'b0;
                n_width          = r_width + WIDTH_W'(1);
                n_limit          = r_limit << 1;
            end else begin
                n_out.code_value = 14'(r_req.code);
                n_out.code_bits  = r_width;
                n_out.is_escape  = 1'b0;
                n_out.last_code  = r_req.last;
                if (r_req.last) begin
                    n_width = START_WIDTH;
                    n_limit = CNT_W'(LIT_COUNT);
                end
            end
        end else if (out_free) begin
            n_out_v = 1'b0;
        end
        if (o_req_ready) begin
            n_req_v = i_req_valid;
            n_req   = i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_v <= 1'b0;
            r_out_v <= 1'b0;
            r_width <= START_WIDTH;
            r_limit <= CNT_W'(LIT_COUNT);
        end else begin
            r_req_v <= n_req_v;
            r_out_v <= n_out_v;
            r_width <= n_width;
            r_limit <= n_limit;
        end
        r_req <= n_req;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

@@ hdl/lzwsc_core.sv @@
`timescale 1ns / 1ps

module lzwsc_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_buf_valid,
    input  lzwsc_pkg::t_in        i_buf,
    output logic                  o_take,
    output logic                  o_clearing,
    output logic                  o_req_valid,
    output lzwsc_pkg::t_emit_req  o_req,
    input  logic                  i_req_ready
);
    import lzwsc_pkg::*;

    t_core_state          r_state, n_state;
    logic [CODE_W-1:0]    r_match, n_match;
    logic                 r_match_v, n_match_v;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [EPOCH_W-1:0]   r_epoch, n_epoch;
    logic [BKT_W-1:0]     r_clr, n_clr;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [BKT_W-1:0]     r_addr, n_addr;
    logic [BYTE_W-1:0]    r_byte, n_byte;
    logic                 r_eos, n_eos;
    t_emit_req            r_pend, n_pend;
    logic                 r_flush, n_flush;

    logic                 we;
    logic [BKT_W-1:0]     waddr;
    t_bucket              wdata;
    logic [BKT_W-1:0]     raddr;
    logic [BUCKET_W-1:0]  rdata_raw;
    t_bucket              rd;
    logic [KEY_W-1:0]     new_key;
    logic                 live;
    logic                 hit;
    logic                 empty;

    // Lookup table: each bucket holds the pair and its code.
    lzwsc_ram #(
        .WIDTH (BUCKET_W),
        .DEPTH (LOOKUP_BUCKETS)
    ) u_lookup (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    assign rd      = t_bucket'(rdata_raw);
    assign new_key = {r_match, i_buf.data_byte};
    assign live    = (rd.epoch == r_epoch);
    assign hit     = live && (rd.key == r_key);
    assign empty   = !live;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_buf_valid) begin
                    if (!r_match_v) begin
                        n_state = i_buf.end_of_stream ? S_EMIT : S_IDLE;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (hit) begin
                    n_state = r_eos ? S_EMIT : S_IDLE;
                end else if (empty) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_req_ready && !r_flush) begin
                    if (r_pend.last && (r_epoch == EPOCH_MAX)) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CLEAR: begin
                if (r_clr == {BKT_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory access and handshake outputs.
    always_comb begin
        n_match   = r_match;
        n_match_v = r_match_v;
        n_count   = r_count;
        n_epoch   = r_epoch;
        n_clr     = r_clr;
        n_key     = r_key;
        n_addr    = r_addr;
        n_byte    = r_byte;
        n_eos     = r_eos;
        n_pend    = r_pend;
        n_flush   = r_flush;
        we        = 1'b0;
        waddr     = r_addr;
        wdata     = '0;
        raddr     = r_addr + BKT_W'(1);
        o_take    = 1'b0;
        o_req_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                raddr  = bucket_of(new_key);
                o_take = i_buf_valid;
                if (i_buf_valid) begin
                    n_key  = new_key;
                    n_addr = bucket_of(new_key);
                    n_byte = i_buf.data_byte;
                    n_eos  = i_buf.end_of_stream;
                    if (!r_match_v) begin
                        n_match   = CODE_W'(i_buf.data_byte);
                        n_match_v = 1'b1;
                        n_pend    = '{code: CODE_W'(i_buf.data_byte), last: 1'b1};
                        n_flush   = 1'b0;
                    end
                end
            end
            S_PROBE: begin
                if (hit) begin
                    n_match = rd.code;
                    n_pend  = '{code: rd.code, last: 1'b1};
                    n_flush = 1'b0;
                end else if (empty) begin
                    // Miss: send the match, add the pair if the dictionary has room, restart at the byte.
                    n_pend  = '{code: r_match, last: 1'b0};
                    n_flush = r_eos;
                    n_match = CODE_W'(r_byte);
                    if (r_count < CNT_W'(DICT_ENTRIES)) begin
                        we      = 1'b1;
                        wdata   = '{epoch: r_epoch, key: r_key, code: r_count[CODE_W-1:0]};
                        n_count = r_count + CNT_W'(1);
                    end
                end else begin
                    n_addr = r_addr + BKT_W'(1);
                end
            end
            S_EMIT: begin
                o_req_valid = 1'b1;
                if (i_req_ready) begin
                    if (r_flush) begin
                        n_pend  = '{code: r_match, last: 1'b1};
                        n_flush = 1'b0;
                    end else if (r_pend.last) begin
                        // End of stream: empty the dictionary by moving the epoch.
                        n_count   = CNT_W'(LIT_COUNT);
                        n_match   = '0;
                        n_match_v = 1'b0;
                        if (r_epoch == EPOCH_MAX) begin
                            n_epoch = EPOCH_FIRST;
                            n_clr   = '0;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                        end
                    end
                end
            end
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + BKT_W'(1);
            end
            default: begin
                n_match_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_match   <= '0;
            r_match_v <= 1'b0;
            r_count   <= CNT_W'(LIT_COUNT);
            r_epoch   <= EPOCH_FIRST;
            r_clr     <= '0;
            r_flush   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_match   <= n_match;
            r_match_v <= n_match_v;
            r_count   <= n_count;
            r_epoch   <= n_epoch;
            r_clr     <= n_clr;
            r_flush   <= n_flush;
        end
        r_key  <= n_key;
        r_addr <= n_addr;
        r_byte <= n_byte;
        r_eos  <= n_eos;
        r_pend <= n_pend;
    end

    assign o_req      = r_pend;
    assign o_clearing = (r_state == S_CLEAR);

endmodule

@@ hdl/lzw_stream_compressor.sv @@
`timescale 1ns / 1ps
// LZW code generator with variable code width; bit packing is done downstream.
// Input channel: one byte per transaction with an end-of-stream flag
// (i_in_valid / o_in_stall). Output channel: one code per transaction with its
// bit width, an escape flag and a last-code flag (o_out_valid / i_out_stall).
// A byte that extends the current match has its lookup bucket read in S_IDLE
// and checked in S_PROBE; each further probe of a collision chain stays in
// S_PROBE, and each code is handed to the output sequencer from S_EMIT.
// The lookup memory has a single read port.
// A code reaches the output through S_EMIT, the sequencer's request register
// and its output register; escapes leave one per cycle, while the output does
// not stall, ahead of the code they precede.
// A one-entry input buffer takes the next byte while the current one is in
// the dictionary; o_in_stall is high while the buffer still holds a byte or a
// clearing pass runs, so no new byte enters until the engine takes the last.
// The sequencer's request register takes one more code while the receiver
// stalls; a longer stall backs up into the dictionary engine and then the input.
// After reset, and after every 255th stream, a clearing pass writes all 32768
// lookup buckets; the input stalls meanwhile.
// The final byte of a stream flushes the last code and empties the dictionary.

module lzw_stream_compressor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lzwsc_pkg::t_in    i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lzwsc_pkg::t_out   o_out
);
    import lzwsc_pkg::*;

    logic       r_buf_v, n_buf_v;
    t_in        r_buf, n_buf;
    logic       take;
    logic       clearing;
    logic       accept;
    logic       req_valid;
    t_emit_req  req;
    logic       req_ready;

    // Input buffer: holds one transaction until the dictionary engine takes it.
    assign o_in_stall = r_buf_v || clearing;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_buf_v = r_buf_v;
        n_buf   = r_buf;
        if (accept) begin
            n_buf_v = 1'b1;
            n_buf   = i_in;
        end else if (take) begin
            n_buf_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_v <= 1'b0;
        end else begin
            r_buf_v <= n_buf_v;
        end
        r_buf <= n_buf;
    end

    lzwsc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_buf_valid (r_buf_v),
        .i_buf       (r_buf),
        .o_take      (take),
        .o_clearing  (clearing),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    lzwsc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
